[rtl/ledek_pkg.sv]
// shared types and constants of the line editor with erase and kill
package ledek_pkg;

    // character codes
    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] ERASE_RESET     = 8'd35;
    localparam logic [7:0] KILL_RESET      = 8'd64;

    // configuration register indexes
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_ERASE_CHAR = 1'b0;
    localparam reg_idx_t REG_KILL_CHAR  = 1'b1;

    // command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // operations passed from the front to the back
    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_ERASE    = 2'd1,
        OP_KILL     = 2'd2,
        OP_LINE_END = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

endpackage

[rtl/ledek_front.sv]
// front end: accepts characters, holds the edit codes, classifies into commands
module ledek_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_char,
    input  logic               end_of_text,
    input  logic               cfg_wr_en,
    input  ledek_pkg::reg_idx_t cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               q_full,
    output logic               push,
    output ledek_pkg::cmd_t    push_cmd
);
    import ledek_pkg::*;

    logic [7:0] erase_char_reg;
    logic [7:0] kill_char_reg;
    logic       started_reg;
    logic       started_next;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_char_reg <= ERASE_RESET;
            kill_char_reg  <= KILL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ERASE_CHAR: erase_char_reg <= cfg_wdata;
                REG_KILL_CHAR:  kill_char_reg  <= cfg_wdata;
                default:        erase_char_reg <= erase_char_reg;
            endcase
        end
    end

    // classify the incoming transaction
    always_comb
    begin
        push          = 1'b0;
        push_cmd.op   = OP_APPEND;
        push_cmd.ch   = in_char;
        started_next  = started_reg;
        if (accept)
        begin
            priority if (end_of_text)
            begin
                push         = started_reg;
                push_cmd.op  = OP_LINE_END;
                started_next = 1'b0;
            end
            else if (in_char == NEWLINE_CODE)
            begin
                push         = 1'b1;
                push_cmd.op  = OP_LINE_END;
                started_next = 1'b0;
            end
            else if (in_char == erase_char_reg)
            begin
                push         = 1'b1;
                push_cmd.op  = OP_ERASE;
                started_next = 1'b1;
            end
            else if (in_char == kill_char_reg)
            begin
                push         = 1'b1;
                push_cmd.op  = OP_KILL;
                started_next = 1'b1;
            end
            else
            begin
                push         = 1'b1;
                push_cmd.op  = OP_APPEND;
                started_next = 1'b1;
            end
        end
    end

    // line started flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            started_reg <= 1'b0;
        else
            started_reg <= started_next;
    end

endmodule

[rtl/ledek_queue.sv]
// two-entry command queue between front and back
module ledek_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ledek_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output ledek_pkg::cmd_t head_cmd
);
    import ledek_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

[rtl/ledek_back.sv]
// back end: line store, edit commands and line drain to the output register
module ledek_back #(
    parameter int LINE_DEPTH = 63
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ledek_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_char,
    output logic            last_of_line,
    output logic            line_overflowed
);
    import ledek_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_LOAD  = 4'b0100,
        S_CLOSE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [7:0]      store_mem [LINE_DEPTH];
    logic [7:0]      rdata_reg;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   idx_inc;
    logic            ovf_reg, ovf_next;
    logic            wr_en;
    logic            rd_en;
    logic            out_free;
    logic            load;
    logic [7:0]      load_char;
    logic            load_last;
    logic            out_valid_reg;
    logic [7:0]      out_char_reg;
    logic            last_reg;
    logic            ovf_out_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign idx_inc  = idx_reg + CW'(1);

    // command execution and drain sequencing
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        load_char  = rdata_reg;
        load_last  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.op)
                        OP_APPEND:
                        begin
                            if (fill_reg < CW'(LINE_DEPTH))
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        OP_ERASE:
                        begin
                            if (fill_reg != '0)
                                fill_next = fill_reg - CW'(1);
                        end
                        OP_KILL:
                        begin
                            fill_next = '0;
                            ovf_next  = 1'b0;
                        end
                        OP_LINE_END:
                        begin
                            idx_next   = '0;
                            state_next = (fill_reg == '0) ? S_CLOSE : S_READ;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == fill_reg) ? S_CLOSE : S_READ;
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_char  = NEWLINE_CODE;
                    load_last  = 1'b1;
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // line store, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[fill_reg[AW-1:0]] <= head_cmd.ch;
        if (rd_en)
            rdata_reg <= store_mem[idx_reg[AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= load_char;
            last_reg     <= load_last;
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_char        = out_char_reg;
    assign last_of_line    = last_reg;
    assign line_overflowed = ovf_out_reg;

endmodule

[rtl/line_editor_erase_kill_unit.sv]
// top level of the line editor with erase and kill characters
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_char, end_of_text
//  out       output     out_valid / out_ready  out_char, last_of_line, line_overflowed
//  cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
// an ordinary, erase or kill character is executed in S_IDLE as it is popped from the queue
// a line end is taken in S_IDLE, each stored character is read in S_READ and loaded in S_LOAD,
// and S_CLOSE loads the newline; the S_READ step comes from the registered read port
// a two-entry command queue lets the front keep accepting while the back drains
// in_ready drops only when the queue is full; a stalled output holds the drain
// reset clears control state only; the line store is not cleared
module line_editor_erase_kill_unit #(
    parameter int LINE_DEPTH = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    input  logic                end_of_text,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                last_of_line,
    output logic                line_overflowed,
    input  logic                cfg_wr_en,
    input  ledek_pkg::reg_idx_t cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import ledek_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // accept and classify
    ledek_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .end_of_text(end_of_text),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // command queue
    ledek_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    // execute and drain
    ledek_back #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_of_line   (last_of_line),
        .line_overflowed(line_overflowed)
    );

endmodule

[rtl/ledek_checker.sv]
// port-level checks of the line editor, bound to the top level
module ledek_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_of_line,
    input logic       line_overflowed
);
    import ledek_pkg::*;

    // the closing transaction of a line always carries the newline code
    a_close_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_line) |-> (out_char == NEWLINE_CODE))
        else $error("closing transaction without newline code");

    // the overflow mark is the same on every transaction of one line
    a_overflow_per_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_line) |=>
            (!out_valid || (line_overflowed == $past(line_overflowed))))
        else $error("overflow mark changed within a line");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char)))
        else $error("stalled output dropped or changed");

endmodule

bind line_editor_erase_kill_unit ledek_checker u_ledek_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .last_of_line   (last_of_line),
    .line_overflowed(line_overflowed)
);
